/* rtl/abp_pkg.sv */
// Shared types, constants and the payload checksum for the alternating-bit
// endpoints. No dependencies; every other file refers to it by scoped names.
package abp_pkg;

   localparam int FIFO_DEPTH    = 16;
   localparam int PAYLOAD_BYTES = 20;
   localparam int PTR_W         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(FIFO_DEPTH - 1);

   typedef enum logic [1:0] {
      OP_NEW_MSG     = 2'd0,
      OP_AT_SENDER   = 2'd1,
      OP_TIMEOUT     = 2'd2,
      OP_AT_RECEIVER = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_SENT          = 4'd0,
      ST_QUEUED        = 4'd1,
      ST_DROPPED_FULL  = 4'd2,
      ST_ACKED         = 4'd3,
      ST_IGNORED       = 4'd4,
      ST_CORRUPT       = 4'd5,
      ST_WRONG_ACK     = 4'd6,
      ST_RESENT        = 4'd7,
      ST_TIMER_IGNORED = 4'd8,
      ST_DELIVERED     = 4'd9,
      ST_DUPLICATE     = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      TIMER_NONE  = 2'd0,
      TIMER_START = 2'd1,
      TIMER_STOP  = 2'd2
   } timer_type;

   // Byte 0 sits at the least significant end of word0.
   typedef struct packed {
      logic [31:0] word2;
      logic [63:0] word1;
      logic [63:0] word0;
   } payload_type;

   typedef struct packed {
      status_type         status;
      logic               send_valid;
      logic               send_from_receiver;
      logic               out_seq;
      logic               out_ack;
      logic signed [31:0] out_check;
      logic [63:0]        out_word0;
      logic [63:0]        out_word1;
      logic [31:0]        out_word2;
      logic               deliver_valid;
      timer_type          timer_action;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // Wrapping sum of the payload bytes, each taken as a signed byte.
   function automatic logic [31:0] payload_sum(input payload_type p);
      logic [PAYLOAD_BYTES*8-1:0] flat;
      logic [31:0]                s;
      flat = p;
      s    = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         s = s + {{24{flat[i*8+7]}}, flat[i*8 +: 8]};
      end
      return s;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
   endfunction

endpackage

/* rtl/abp_if.sv */
// Request and response channel interfaces with valid/ready handshake.
// Depends on abp_pkg for the field types.
interface abp_req_if;
   abp_pkg::op_type    op;
   logic signed [31:0] seq_number;
   logic signed [31:0] ack_number;
   logic signed [31:0] check_value;
   logic [63:0]        payload_word0;
   logic [63:0]        payload_word1;
   logic [31:0]        payload_word2;
   logic               valid;
   logic               ready;

   modport source (output op, seq_number, ack_number, check_value, payload_word0,
                   payload_word1, payload_word2, valid, input ready);
   modport sink   (input op, seq_number, ack_number, check_value, payload_word0,
                   payload_word1, payload_word2, valid, output ready);
endinterface

interface abp_rsp_if;
   abp_pkg::status_type status;
   logic                send_valid;
   logic                send_from_receiver;
   logic                out_seq;
   logic                out_ack;
   logic signed [31:0]  out_check;
   logic [63:0]         out_word0;
   logic [63:0]         out_word1;
   logic [31:0]         out_word2;
   logic                deliver_valid;
   abp_pkg::timer_type  timer_action;
   logic                valid;
   logic                ready;

   modport source (output status, send_valid, send_from_receiver, out_seq, out_ack,
                   out_check, out_word0, out_word1, out_word2, deliver_valid,
                   timer_action, valid, input ready);
   modport sink   (input status, send_valid, send_from_receiver, out_seq, out_ack,
                   out_check, out_word0, out_word1, out_word2, deliver_valid,
                   timer_action, valid, output ready);
endinterface

/* rtl/abp_msg_fifo.sv */
// Sender message queue: a circular store of payloads with head/tail pointers.
// Depends on abp_pkg.
module abp_msg_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  abp_pkg::fifo_ctrl_type ctrl,
   input  abp_pkg::payload_type   push_data,
   output abp_pkg::payload_type   head_data,
   output abp_pkg::fifo_stat_type stat
);

   logic [abp_pkg::PTR_W-1:0] head_ff, head_in;
   logic [abp_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [abp_pkg::CNT_W-1:0] count_ff, count_in;
   abp_pkg::payload_type      store_ff [abp_pkg::FIFO_DEPTH];
   logic                      do_push;
   logic                      do_pop;

   assign stat.full  = (count_ff == abp_pkg::FULL_COUNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = ctrl.push && !stat.full;
   assign do_pop     = ctrl.pop && !stat.empty;

   // Forward a request written this cycle into an empty queue.
   assign head_data = (do_push && head_ff == tail_ff) ? push_data : store_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in  = abp_pkg::next_ptr(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (do_pop) begin
         head_in  = abp_pkg::next_ptr(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail_ff] <= push_data;
      end
   end

endmodule

/* rtl/abp_rsp_buf.sv */
// Response register with a skid entry, so a request can be taken while a
// result waits. Depends on abp_pkg and abp_rsp_if.
module abp_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  abp_pkg::rsp_type push_data,
   output logic             push_ready,
   abp_rsp_if.source        rsp
);

   abp_pkg::rsp_type main_ff, main_in;
   abp_pkg::rsp_type skid_ff, skid_in;
   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             pop;

   assign push_ready = !skid_valid_ff;
   assign pop        = main_valid_ff && rsp.ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff && !pop;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (!main_valid_ff || pop) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            // hold the new result until the output drains
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid              = main_valid_ff;
   assign rsp.status             = main_ff.status;
   assign rsp.send_valid         = main_ff.send_valid;
   assign rsp.send_from_receiver = main_ff.send_from_receiver;
   assign rsp.out_seq            = main_ff.out_seq;
   assign rsp.out_ack            = main_ff.out_ack;
   assign rsp.out_check          = main_ff.out_check;
   assign rsp.out_word0          = main_ff.out_word0;
   assign rsp.out_word1          = main_ff.out_word1;
   assign rsp.out_word2          = main_ff.out_word2;
   assign rsp.deliver_valid      = main_ff.deliver_valid;
   assign rsp.timer_action       = main_ff.timer_action;

endmodule

/* rtl/alternating_bit_arq_endpoints_core.sv */
// Alternating-bit stop-and-wait sender and receiver endpoints.
// Depends on abp_pkg, abp_if, abp_msg_fifo and abp_rsp_buf.
//
// Usage:
//   req_chan carries one event per request: a new message, a packet at the
//   sender, a retransmit timer expiry or a packet at the receiver, with the
//   packet header, checksum and 20 payload bytes. rsp_chan returns exactly
//   one result per request: a status code, the packet to put on the network
//   (data from the sender or ack from the receiver), delivered data and the
//   timer command.
//   The result of an accepted request is registered in the response register,
//   or in the skid entry when the output stalls. Throughput is one request per
//   cycle while req_chan.ready is high; the checksum adder tree and the single-bit
//   state updates all settle between the request port and the response register.
//   Messages wait in a 16-entry queue; a new message that finds it full is
//   dropped, and the idle sender still sends the oldest queued one.
//   Reset (synchronous) empties the queue, makes the sender idle and clears
//   both sequence bits; no clearing pass is needed.
//   When the receiver stalls, one further result is held in a skid entry;
//   req_chan.ready then falls until the response register drains.
module alternating_bit_arq_endpoints_core (
   input  logic     clock,
   input  logic     reset,
   abp_req_if.sink  req_chan,
   abp_rsp_if.source rsp_chan
);

   logic                   accept;
   logic                   buf_ready;
   abp_pkg::payload_type   req_payload;
   abp_pkg::payload_type   head_data;
   abp_pkg::fifo_ctrl_type fifo_ctrl;
   abp_pkg::fifo_stat_type fifo_stat;
   abp_pkg::rsp_type       res;
   logic                   push_ok;
   logic                   pop_req;
   logic                   chk_ok;

   logic                   waiting_ff, waiting_in;
   logic                   sender_seq_ff, sender_seq_in;
   logic                   receiver_seq_ff, receiver_seq_in;
   logic                   kept_seq_ff, kept_seq_in;
   logic [31:0]            kept_check_ff, kept_check_in;
   abp_pkg::payload_type   kept_payload_ff, kept_payload_in;

   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   assign req_payload.word0 = req_chan.payload_word0;
   assign req_payload.word1 = req_chan.payload_word1;
   assign req_payload.word2 = req_chan.payload_word2;

   assign chk_ok = (req_chan.check_value == req_chan.seq_number + req_chan.ack_number
                    + abp_pkg::payload_sum(req_payload));

   assign push_ok        = (req_chan.op == abp_pkg::OP_NEW_MSG) && !fifo_stat.full;
   assign fifo_ctrl.push = accept && push_ok;
   assign fifo_ctrl.pop  = accept && pop_req;

   abp_msg_fifo u_msg_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_data (req_payload),
      .head_data (head_data),
      .stat      (fifo_stat)
   );

   always_comb begin
      res             = '0;
      pop_req         = 1'b0;
      waiting_in      = waiting_ff;
      sender_seq_in   = sender_seq_ff;
      receiver_seq_in = receiver_seq_ff;
      kept_seq_in     = kept_seq_ff;
      kept_check_in   = kept_check_ff;
      kept_payload_in = kept_payload_ff;
      case (req_chan.op)
         abp_pkg::OP_NEW_MSG: begin
            if (waiting_ff || (fifo_stat.empty && !push_ok)) begin
               res.status = fifo_stat.full ? abp_pkg::ST_DROPPED_FULL : abp_pkg::ST_QUEUED;
            end else begin
               kept_payload_in  = head_data;
               kept_seq_in      = sender_seq_ff;
               kept_check_in    = {31'b0, sender_seq_ff} + abp_pkg::payload_sum(head_data);
               waiting_in       = 1'b1;
               res.status       = fifo_stat.full ? abp_pkg::ST_DROPPED_FULL : abp_pkg::ST_SENT;
               res.send_valid   = 1'b1;
               res.out_seq      = sender_seq_ff;
               res.out_check    = kept_check_in;
               res.out_word0    = head_data.word0;
               res.out_word1    = head_data.word1;
               res.out_word2    = head_data.word2;
               res.timer_action = abp_pkg::TIMER_START;
            end
         end
         abp_pkg::OP_AT_SENDER: begin
            if (!waiting_ff) begin
               res.status = abp_pkg::ST_IGNORED;
            end else if (!chk_ok) begin
               res.status = abp_pkg::ST_CORRUPT;
            end else if (req_chan.ack_number != {31'b0, sender_seq_ff}) begin
               res.status = abp_pkg::ST_WRONG_ACK;
            end else begin
               // acked: flip the bit, release the message, go idle
               res.status       = abp_pkg::ST_ACKED;
               res.timer_action = abp_pkg::TIMER_STOP;
               sender_seq_in    = ~sender_seq_ff;
               pop_req          = 1'b1;
               waiting_in       = 1'b0;
            end
         end
         abp_pkg::OP_TIMEOUT: begin
            if (!waiting_ff) begin
               res.status = abp_pkg::ST_TIMER_IGNORED;
            end else begin
               res.status       = abp_pkg::ST_RESENT;
               res.send_valid   = 1'b1;
               res.out_seq      = kept_seq_ff;
               res.out_check    = kept_check_ff;
               res.out_word0    = kept_payload_ff.word0;
               res.out_word1    = kept_payload_ff.word1;
               res.out_word2    = kept_payload_ff.word2;
               res.timer_action = abp_pkg::TIMER_START;
            end
         end
         abp_pkg::OP_AT_RECEIVER: begin
            if (!chk_ok) begin
               res.status = abp_pkg::ST_CORRUPT;
            end else begin
               res.send_valid         = 1'b1;
               res.send_from_receiver = 1'b1;
               if (req_chan.seq_number == {31'b0, receiver_seq_ff}) begin
                  res.status        = abp_pkg::ST_DELIVERED;
                  res.out_ack       = receiver_seq_ff;
                  res.out_check     = {31'b0, receiver_seq_ff};
                  res.out_word0     = req_chan.payload_word0;
                  res.out_word1     = req_chan.payload_word1;
                  res.out_word2     = req_chan.payload_word2;
                  res.deliver_valid = 1'b1;
                  receiver_seq_in   = ~receiver_seq_ff;
               end else begin
                  // duplicate: re-ack the previous sequence bit
                  res.status    = abp_pkg::ST_DUPLICATE;
                  res.out_ack   = ~receiver_seq_ff;
                  res.out_check = {31'b0, ~receiver_seq_ff};
               end
            end
         end
         default: begin
            res.status = abp_pkg::ST_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff      <= 1'b0;
         sender_seq_ff   <= 1'b0;
         receiver_seq_ff <= 1'b0;
         kept_seq_ff     <= 1'b0;
         kept_check_ff   <= '0;
      end else if (accept) begin
         waiting_ff      <= waiting_in;
         sender_seq_ff   <= sender_seq_in;
         receiver_seq_ff <= receiver_seq_in;
         kept_seq_ff     <= kept_seq_in;
         kept_check_ff   <= kept_check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kept_payload_ff <= kept_payload_in;
      end
   end

   abp_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_data  (res),
      .push_ready (buf_ready),
      .rsp        (rsp_chan)
   );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for the alternating-bit sender/receiver endpoints.
// Needs abp_pkg, the abp_req_if/abp_rsp_if interfaces and the core from rtl/.
// Runs a directed table, then protocol-shaped random traffic, against a predictor.
module tb_top;

   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      abp_pkg::op_type      op;
      logic signed [31:0]   seq;
      logic signed [31:0]   ack;
      logic signed [31:0]   chk;
      abp_pkg::payload_type pay;
   } req_item_type;

   typedef struct {
      req_item_type     it;
      bit               typed;
      abp_pkg::rsp_type want;
   } stim_row_type;

   typedef enum {MODE_FILL, MODE_FLOW, MODE_NOISE} traffic_mode_type;

   logic clock;
   logic reset;

   abp_req_if req_chan ();
   abp_rsp_if rsp_chan ();

   alternating_bit_arq_endpoints_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted endpoint state
   logic                 tx_busy  = 1'b0;
   logic                 tx_seq   = 1'b0;
   logic                 held_seq = 1'b0;
   logic [31:0]          held_chk = '0;
   abp_pkg::payload_type held_pay = '0;
   abp_pkg::payload_type msg_q [abp_pkg::FIFO_DEPTH];
   int                   q_head   = 0;
   int                   q_tail   = 0;
   int                   q_count  = 0;
   logic                 rx_seq   = 1'b0;

   abp_pkg::rsp_type awaited [$];
   stim_row_type     script [$];
   int               mismatches   = 0;
   int               results_seen = 0;
   int               cycle_count  = 0;
   bit               calm         = 1'b0;
   bit               holding      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [31:0] signed_byte_total(input abp_pkg::payload_type p);
      logic [abp_pkg::PAYLOAD_BYTES*8-1:0] bytes;
      logic signed [7:0]                   b;
      logic [31:0]                         acc;
      int                                  k;
      bytes = p;
      acc   = '0;
      for (k = 0; k < abp_pkg::PAYLOAD_BYTES; k++) begin
         b   = bytes[8*k +: 8];
         acc = acc + 32'(b);
      end
      return acc;
   endfunction

   function automatic abp_pkg::rsp_type endpoint_step(input req_item_type it);
      abp_pkg::rsp_type r;
      logic             full;
      logic [31:0]      sum_ok;
      r      = '0;
      sum_ok = it.seq + it.ack + signed_byte_total(it.pay);
      case (it.op)
         abp_pkg::OP_NEW_MSG: begin
            full = (q_count >= abp_pkg::FIFO_DEPTH);
            if (!full) begin
               msg_q[q_tail] = it.pay;
               q_tail        = (q_tail + 1) % abp_pkg::FIFO_DEPTH;
               q_count++;
            end
            if (tx_busy || q_count == 0) begin
               if (full) r.status = abp_pkg::ST_DROPPED_FULL;
               else r.status = abp_pkg::ST_QUEUED;
            end else begin
               held_pay = msg_q[q_head];
               held_seq = tx_seq;
               held_chk = {31'b0, tx_seq} + signed_byte_total(held_pay);
               tx_busy  = 1'b1;
               if (full) r.status = abp_pkg::ST_DROPPED_FULL;
               else r.status = abp_pkg::ST_SENT;
               r.send_valid   = 1'b1;
               r.out_seq      = held_seq;
               r.out_check    = held_chk;
               r.out_word0    = held_pay.word0;
               r.out_word1    = held_pay.word1;
               r.out_word2    = held_pay.word2;
               r.timer_action = abp_pkg::TIMER_START;
            end
         end
         abp_pkg::OP_AT_SENDER: begin
            if (!tx_busy) r.status = abp_pkg::ST_IGNORED;
            else if (it.chk != sum_ok) r.status = abp_pkg::ST_CORRUPT;
            else if (it.ack != {31'b0, tx_seq}) r.status = abp_pkg::ST_WRONG_ACK;
            else begin
               r.status       = abp_pkg::ST_ACKED;
               r.timer_action = abp_pkg::TIMER_STOP;
               tx_seq         = ~tx_seq;
               if (q_count > 0) begin
                  q_head = (q_head + 1) % abp_pkg::FIFO_DEPTH;
                  q_count--;
               end
               tx_busy = 1'b0;
            end
         end
         abp_pkg::OP_TIMEOUT: begin
            if (!tx_busy) r.status = abp_pkg::ST_TIMER_IGNORED;
            else begin
               r.status       = abp_pkg::ST_RESENT;
               r.send_valid   = 1'b1;
               r.out_seq      = held_seq;
               r.out_check    = held_chk;
               r.out_word0    = held_pay.word0;
               r.out_word1    = held_pay.word1;
               r.out_word2    = held_pay.word2;
               r.timer_action = abp_pkg::TIMER_START;
            end
         end
         default: begin
            if (it.chk != sum_ok) r.status = abp_pkg::ST_CORRUPT;
            else begin
               r.send_valid         = 1'b1;
               r.send_from_receiver = 1'b1;
               if (it.seq == {31'b0, rx_seq}) begin
                  r.status        = abp_pkg::ST_DELIVERED;
                  r.out_ack       = rx_seq;
                  r.out_check     = {31'b0, rx_seq};
                  r.out_word0     = it.pay.word0;
                  r.out_word1     = it.pay.word1;
                  r.out_word2     = it.pay.word2;
                  r.deliver_valid = 1'b1;
                  rx_seq          = ~rx_seq;
               end else begin
                  // re-ack the last in-order packet
                  r.status    = abp_pkg::ST_DUPLICATE;
                  r.out_ack   = ~rx_seq;
                  r.out_check = {31'b0, ~rx_seq};
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic abp_pkg::payload_type random_payload();
      abp_pkg::payload_type p;
      p.word0 = {$urandom, $urandom};
      p.word1 = {$urandom, $urandom};
      p.word2 = $urandom;
      return p;
   endfunction

   function automatic req_item_type random_item(input abp_pkg::op_type op);
      req_item_type it;
      it.op  = op;
      it.seq = $urandom;
      it.ack = $urandom;
      it.chk = $urandom;
      it.pay = random_payload();
      return it;
   endfunction

   // Ack towards the sender, checksum made good
   function automatic req_item_type ack_packet(input logic [31:0] ack_val);
      req_item_type it;
      it.op  = abp_pkg::OP_AT_SENDER;
      it.seq = ($urandom_range(0, 3) == 0) ? $urandom : 0;
      it.ack = ack_val;
      it.pay = ($urandom_range(0, 4) == 0) ? random_payload() : '0;
      it.chk = it.seq + it.ack + signed_byte_total(it.pay);
      return it;
   endfunction

   function automatic req_item_type spoil(input req_item_type it);
      if ($urandom_range(0, 1)) it.chk = it.chk ^ (32'd1 << $urandom_range(0, 31));
      else it.pay.word1 = it.pay.word1 ^ (64'd1 << $urandom_range(0, 63));
      return it;
   endfunction

   function automatic req_item_type next_event(input traffic_mode_type mode);
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      if (mode == MODE_NOISE || pick < 5)
         return random_item(abp_pkg::op_type'($urandom_range(0, 3)));
      if ((mode == MODE_FILL && pick < 85) || (!tx_busy && pick < 55) || (tx_busy && pick < 20))
         return random_item(abp_pkg::OP_NEW_MSG);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // the data packet the sender last put on the wire
         it.op  = abp_pkg::OP_AT_RECEIVER;
         it.seq = {31'b0, held_seq};
         it.ack = 0;
         it.chk = held_chk;
         it.pay = held_pay;
      end else if (pick < 80) begin
         it = ack_packet((pick < 70) ? {31'b0, tx_seq} : {31'b0, ~tx_seq});
      end else if (pick < 90) begin
         it     = random_item(abp_pkg::OP_AT_RECEIVER);
         it.seq = $urandom_range(0, 2) ? $urandom_range(0, 1) : $urandom;
         it.chk = it.seq + it.ack + signed_byte_total(it.pay);
      end else begin
         it = random_item(abp_pkg::OP_TIMEOUT);
      end
      if ($urandom_range(0, 9) == 0) it = spoil(it);
      return it;
   endfunction

   function automatic abp_pkg::rsp_type only_status(input abp_pkg::status_type s);
      abp_pkg::rsp_type r;
      r        = '0;
      r.status = s;
      return r;
   endfunction

   function automatic void add_row(input abp_pkg::op_type op, input logic [31:0] seq,
                                   input logic [31:0] ack, input logic [31:0] chk,
                                   input abp_pkg::payload_type pay, input bit typed,
                                   input abp_pkg::rsp_type want);
      stim_row_type row;
      row.it.op  = op;
      row.it.seq = seq;
      row.it.ack = ack;
      row.it.chk = chk;
      row.it.pay = pay;
      row.typed  = typed;
      row.want   = want;
      script.push_back(row);
   endfunction

   task automatic drive_one(input req_item_type it, input bit typed,
                            input abp_pkg::rsp_type want,
                            output abp_pkg::status_type st);
      abp_pkg::rsp_type pred;
      int               gap;
      gap = holding ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.op            <= it.op;
      req_chan.seq_number    <= it.seq;
      req_chan.ack_number    <= it.ack;
      req_chan.check_value   <= it.chk;
      req_chan.payload_word0 <= it.pay.word0;
      req_chan.payload_word1 <= it.pay.word1;
      req_chan.payload_word2 <= it.pay.word2;
      req_chan.valid         <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      pred = endpoint_step(it);
      awaited.push_back(typed ? want : pred);
      st = pred.status;
   endtask

   initial begin : stimulus
      abp_pkg::payload_type ones;
      abp_pkg::payload_type pat;
      abp_pkg::rsp_type     dup;
      abp_pkg::rsp_type     stop;
      req_item_type         it;
      traffic_mode_type     mode;
      abp_pkg::status_type  st;
      int                   counted;
      int                   seg_len;

      req_chan.valid         <= 1'b0;
      req_chan.op            <= abp_pkg::OP_NEW_MSG;
      req_chan.seq_number    <= '0;
      req_chan.ack_number    <= '0;
      req_chan.check_value   <= '0;
      req_chan.payload_word0 <= '0;
      req_chan.payload_word1 <= '0;
      req_chan.payload_word2 <= '0;

      ones  = '1;
      pat   = '{word2: 32'h8000_7FFF, word1: 64'h807F_807F_807F_807F,
                word0: 64'h7F80_7F80_7F80_7F80};
      dup   = only_status(abp_pkg::ST_DUPLICATE);
      dup.send_valid         = 1'b1;
      dup.send_from_receiver = 1'b1;
      stop  = only_status(abp_pkg::ST_ACKED);
      stop.timer_action      = abp_pkg::TIMER_STOP;

      add_row(abp_pkg::OP_AT_SENDER, 0, 0, 0, '0, 1, only_status(abp_pkg::ST_IGNORED));
      add_row(abp_pkg::OP_TIMEOUT, 0, 0, 0, '0, 1,
              only_status(abp_pkg::ST_TIMER_IGNORED));
      add_row(abp_pkg::OP_AT_RECEIVER, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              '0, 1, only_status(abp_pkg::ST_CORRUPT));
      add_row(abp_pkg::OP_NEW_MSG, 0, 0, 0, ones, 0, '0);
      add_row(abp_pkg::OP_NEW_MSG, 0, 0, 0, '0, 1, only_status(abp_pkg::ST_QUEUED));
      add_row(abp_pkg::OP_TIMEOUT, 0, 0, 0, '0, 0, '0);
      add_row(abp_pkg::OP_AT_SENDER, 0, 1, 1, '0, 1,
              only_status(abp_pkg::ST_WRONG_ACK));
      add_row(abp_pkg::OP_AT_SENDER, 0, 0, 5, '0, 1, only_status(abp_pkg::ST_CORRUPT));
      // upper ack bits set (low bit 1 against sender bit 0): rejected as a wrong ack
      add_row(abp_pkg::OP_AT_SENDER, 0, 32'h101, 32'h101, '0, 1,
              only_status(abp_pkg::ST_WRONG_ACK));
      add_row(abp_pkg::OP_AT_SENDER, 0, 0, 0, '0, 1, stop);
      add_row(abp_pkg::OP_NEW_MSG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pat,
              0, '0);
      add_row(abp_pkg::OP_AT_RECEIVER, 0, 0, 32'hFFFF_FFEC, ones, 0, '0);
      add_row(abp_pkg::OP_AT_RECEIVER, 0, 0, 32'hFFFF_FFEC, ones, 1, dup);
      add_row(abp_pkg::OP_AT_RECEIVER, 32'h8000_0001, 32'h7FFF_FFFF, 0, '0, 0, '0);
      add_row(abp_pkg::OP_AT_RECEIVER, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF + 32'hFFFF_FFFF + signed_byte_total(pat), pat, 0, '0);
      add_row(abp_pkg::OP_AT_RECEIVER, 1, 0, 32'd1 + signed_byte_total(pat), pat,
              0, '0);
      add_row(abp_pkg::OP_AT_SENDER, 0, 1, 1, '0, 0, '0);
      add_row(abp_pkg::OP_TIMEOUT, 0, 0, 0, '0, 1,
              only_status(abp_pkg::ST_TIMER_IGNORED));
      add_row(abp_pkg::OP_NEW_MSG, 0, 0, 0, random_payload(), 0, '0);

      do @(posedge clock); while (reset);

      foreach (script[i]) drive_one(script[i].it, script[i].typed, script[i].want, st);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    begin mode = MODE_FILL;  seg_len = $urandom_range(20, 30); end
            2, 3:    begin mode = MODE_NOISE; seg_len = $urandom_range(5, 15);  end
            default: begin mode = MODE_FLOW;  seg_len = $urandom_range(20, 80); end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            it = next_event(mode);
            drive_one(it, 1'b0, '0, st);
            if (st != abp_pkg::ST_IGNORED && st != abp_pkg::ST_TIMER_IGNORED) counted++;
         end
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // Result side: random back-pressure plus one long hold to fill the block
   initial begin : rsp_drain
      bit hold_done;
      int stall;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            holding   = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat (calm ? $urandom_range(20, 100) : $urandom_range(1, 8)) @(posedge clock);
      end
   end

   function automatic void tally(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d on %s: expected %h, got %h",
                  cycle_count, field, want, got);
   endfunction

   always @(posedge clock) begin : check_rsp
      abp_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result at cycle %0d: status %0d",
                        cycle_count, rsp_chan.status);
         end else begin
            want = awaited.pop_front();
            if (want.status !== rsp_chan.status)
               tally("status", want.status, rsp_chan.status);
            if (want.send_valid !== rsp_chan.send_valid)
               tally("send_valid", want.send_valid, rsp_chan.send_valid);
            if (want.send_from_receiver !== rsp_chan.send_from_receiver)
               tally("send_from_receiver", want.send_from_receiver,
                     rsp_chan.send_from_receiver);
            if (want.out_seq !== rsp_chan.out_seq)
               tally("out_seq", want.out_seq, rsp_chan.out_seq);
            if (want.out_ack !== rsp_chan.out_ack)
               tally("out_ack", want.out_ack, rsp_chan.out_ack);
            if (want.out_check !== rsp_chan.out_check)
               tally("out_check", want.out_check, rsp_chan.out_check);
            if (want.out_word0 !== rsp_chan.out_word0)
               tally("out_word0", want.out_word0, rsp_chan.out_word0);
            if (want.out_word1 !== rsp_chan.out_word1)
               tally("out_word1", want.out_word1, rsp_chan.out_word1);
            if (want.out_word2 !== rsp_chan.out_word2)
               tally("out_word2", want.out_word2, rsp_chan.out_word2);
            if (want.deliver_valid !== rsp_chan.deliver_valid)
               tally("deliver_valid", want.deliver_valid, rsp_chan.deliver_valid);
            if (want.timer_action !== rsp_chan.timer_action)
               tally("timer_action", want.timer_action, rsp_chan.timer_action);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
